>>> hw/rtl/psas_pkg.sv
`default_nettype none
package psas_pkg;

   localparam int MaxBinsDefault = 1024;
   localparam int GroupSize      = 5;

   localparam int BinW    = 16;
   localparam int CountW  = 16;
   localparam int AngleW  = 13;
   localparam int ScoreW  = 52;
   localparam int EnergyW = 48;
   localparam int GsumW   = 19;
   localparam int RatioW  = 32;
   localparam int DivNumW = 56;
   localparam int DivDenW = 48;

   localparam logic [1:0] CsrCenter = 2'd0;
   localparam logic [1:0] CsrDelta  = 2'd1;
   localparam logic [1:0] CsrStep   = 2'd2;

   typedef struct packed {
      logic [BinW-1:0]   bin_value;
      logic              last_bin;
      logic [CountW-1:0] element_count;
      logic              build_failed;
   } item_type;

   typedef struct packed {
      logic               start;
      logic [DivNumW-1:0] num;
      logic [DivDenW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DivNumW-1:0] quo;
   } div_rsp_type;

endpackage
`default_nettype wire

>>> hw/rtl/psas_front.sv
`default_nettype none
module psas_front (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire  [15:0]               req_bin_value,
   input  wire                       req_last_bin,
   input  wire  [15:0]               req_element_count,
   input  wire                       req_build_failed,
   output logic                      q_valid,
   output psas_pkg::item_type        q_item,
   input  wire                       q_pop
);
   import psas_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       push;
   item_type   item_in;

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      item_in.bin_value     = req_bin_value;
      item_in.last_bin      = req_last_bin;
      item_in.element_count = req_element_count;
      item_in.build_failed  = req_build_failed;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop && q_valid) rd_ptr_ff <= ~rd_ptr_ff;
         unique case ({push, q_pop && q_valid})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/psas_div.sv
`default_nettype none
module psas_div (
   input  wire                       clock,
   input  wire                       reset,
   input  psas_pkg::div_req_type     div_req,
   output psas_pkg::div_rsp_type     div_rsp
);
   import psas_pkg::*;

   logic [DivDenW-1:0] rem_ff;
   logic [DivNumW-1:0] num_ff;
   logic [DivDenW-1:0] den_ff;
   logic [5:0]         cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DivDenW:0]   rem_sh;
   logic [DivDenW:0]   rem_sub;
   logic               ge;

   // restoring divide, one quotient bit per cycle; remainder stays below den
   assign rem_sh  = {rem_ff, num_ff[DivNumW-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign ge      = (rem_sh >= {1'b0, den_ff});

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(DivNumW - 1);
            rem_ff  <= '0;
            num_ff  <= div_req.num;
            den_ff  <= div_req.den;
         end else if (busy_ff) begin
            rem_ff <= ge ? rem_sub[DivDenW-1:0] : rem_sh[DivDenW-1:0];
            num_ff <= {num_ff[DivNumW-2:0], ge};
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/psas_back.sv
`default_nettype none
module psas_back #(
   parameter int MAX_BINS = psas_pkg::MaxBinsDefault
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_we,
   input  wire  [1:0]                csr_index,
   input  wire  [11:0]               csr_wdata,
   input  wire                       q_valid,
   input  psas_pkg::item_type        q_item,
   output logic                      q_pop,
   output psas_pkg::div_req_type     div_req,
   input  psas_pkg::div_rsp_type     div_rsp,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic [12:0]               rsp_best_skew,
   output logic [47:0]               rsp_group_energy,
   output logic [31:0]               rsp_row_length,
   output logic [31:0]               rsp_row_count,
   output logic                      rsp_failure
);
   import psas_pkg::*;

   localparam int IdxW = $clog2(MAX_BINS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_ACC, S_SQ, S_ENG, S_CMP,
      S_DIV1, S_WAIT1, S_SQC, S_DIV2, S_WAIT2, S_EMIT
   } state_type;

   state_type            state_ff;
   logic [11:0]          center_ff;
   logic [9:0]           delta_ff;
   logic [7:0]           step_ff;
   logic                 restart_ff;
   item_type             item_ff;
   logic [BinW-1:0]      prev0_ff, prev1_ff;
   logic [IdxW-1:0]      idx_ff;
   logic [2:0]           gpos_ff;
   logic [ScoreW-1:0]    score_ff, best_score_ff;
   logic [GsumW-1:0]     gsum_ff;
   logic [EnergyW-1:0]   energy_ff, best_energy_ff;
   logic [AngleW-1:0]    angle_ff, first_ff, last_ff;
   logic [CountW-1:0]    best_count_ff;
   logic [31:0]          sq_ff, pr0_ff, pr1_ff, cnt2_ff;
   logic [37:0]          gsq_ff;
   logic                 w4_ff, inr_ff, close_ff, fail_ff;
   logic [RatioW-1:0]    len_ff;
   logic                 rsp_valid_ff;

   logic [AngleW-1:0]    start_angle;
   logic [AngleW:0]      end_angle;
   logic [AngleW:0]      angle_next;
   logic [7:0]           step_eff;
   logic [AngleW:0]      mid_sum;
   logic [AngleW:0]      mid_adj;
   logic                 in_range;
   logic [ScoreW-1:0]    score_in;
   logic [RatioW-1:0]    ratio_in;
   logic                 emit_go;

   assign start_angle = AngleW'($signed({center_ff[11], center_ff}) - $signed({3'b000, delta_ff}));
   assign end_angle   = (AngleW+1)'($signed({{2{center_ff[11]}}, center_ff})
                                    + $signed({4'b0000, delta_ff}));
   assign step_eff    = (step_ff == 8'd0) ? 8'd1 : step_ff;
   assign angle_next  = {angle_ff[AngleW-1], angle_ff} + {6'd0, step_eff};
   assign mid_sum     = {first_ff[AngleW-1], first_ff} + {last_ff[AngleW-1], last_ff};
   // halve toward zero: add one to negative sums before the shift
   assign mid_adj     = mid_sum + {{AngleW{1'b0}}, mid_sum[AngleW]};
   assign in_range    = (idx_ff < IdxW'(MAX_BINS));
   assign score_in    = score_ff + ScoreW'({sq_ff, 3'b000}) + ScoreW'({sq_ff, 1'b0})
                        + (w4_ff ? ScoreW'({pr0_ff, 2'b00}) : ScoreW'({pr0_ff, 3'b000}))
                        + ScoreW'({pr1_ff, 1'b0}) + ScoreW'(pr1_ff);
   assign ratio_in    = (div_req.den == '0 || div_rsp.quo[DivNumW-1:RatioW] != '0)
                        ? '1 : div_rsp.quo[RatioW-1:0];
   assign emit_go     = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      div_req.start = (state_ff == S_DIV1) || (state_ff == S_DIV2);
      if (state_ff == S_DIV1 || state_ff == S_WAIT1) begin
         div_req.num = {best_energy_ff, 8'd0};
         div_req.den = DivDenW'(best_count_ff);
      end else begin
         div_req.num = DivNumW'({cnt2_ff, 8'd0});
         div_req.den = best_energy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         center_ff      <= '0;
         delta_ff       <= '0;
         step_ff        <= 8'd1;
         restart_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prev0_ff       <= '0;
         prev1_ff       <= '0;
         idx_ff         <= '0;
         gpos_ff        <= '0;
         score_ff       <= '0;
         gsum_ff        <= '0;
         energy_ff      <= '0;
         angle_ff       <= '0;
         first_ff       <= '0;
         last_ff        <= '0;
         best_score_ff  <= '0;
         best_energy_ff <= '0;
         best_count_ff  <= '0;
      end else begin
         restart_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CsrCenter: begin center_ff <= csr_wdata;       restart_ff <= 1'b1; end
               CsrDelta:  begin delta_ff  <= csr_wdata[9:0];  restart_ff <= 1'b1; end
               CsrStep:   begin step_ff   <= csr_wdata[7:0];  restart_ff <= 1'b1; end
               default:   ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && !emit_go) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_item;
                  fail_ff  <= q_item.build_failed;
                  state_ff <= q_item.build_failed ? S_EMIT : S_MUL;
               end
            end
            S_MUL: begin
               sq_ff    <= 32'(item_ff.bin_value) * 32'(item_ff.bin_value);
               pr0_ff   <= 32'(item_ff.bin_value) * 32'(prev0_ff);
               pr1_ff   <= 32'(item_ff.bin_value) * 32'(prev1_ff);
               w4_ff    <= (idx_ff == IdxW'(1)) || item_ff.last_bin;
               inr_ff   <= in_range;
               close_ff <= in_range && (gpos_ff == 3'(GroupSize - 1));
               if (in_range) begin
                  prev1_ff <= prev0_ff;
                  prev0_ff <= item_ff.bin_value;
                  idx_ff   <= idx_ff + IdxW'(1);
                  gsum_ff  <= gsum_ff + GsumW'(item_ff.bin_value);
                  gpos_ff  <= (gpos_ff == 3'(GroupSize - 1)) ? 3'd0 : gpos_ff + 3'd1;
               end
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (inr_ff) score_ff <= score_in;
               state_ff <= (close_ff || item_ff.last_bin) ? S_SQ : S_IDLE;
            end
            S_SQ: begin
               gsq_ff   <= 38'(gsum_ff) * 38'(gsum_ff);
               state_ff <= S_ENG;
            end
            S_ENG: begin
               energy_ff <= energy_ff + EnergyW'(gsq_ff);
               gsum_ff   <= '0;
               state_ff  <= item_ff.last_bin ? S_CMP : S_IDLE;
            end
            S_CMP: begin
               if (score_ff >= best_score_ff) begin
                  last_ff <= angle_ff;
                  if (score_ff > best_score_ff) first_ff <= angle_ff;
                  best_score_ff  <= score_ff;
                  best_energy_ff <= energy_ff;
                  best_count_ff  <= item_ff.element_count;
               end
               prev0_ff  <= '0;
               prev1_ff  <= '0;
               idx_ff    <= '0;
               gpos_ff   <= '0;
               score_ff  <= '0;
               gsum_ff   <= '0;
               energy_ff <= '0;
               angle_ff  <= angle_next[AngleW-1:0];
               state_ff  <= ($signed(angle_next) > $signed(end_angle)) ? S_DIV1 : S_IDLE;
            end
            S_DIV1:  state_ff <= S_WAIT1;
            S_WAIT1: begin
               if (div_rsp.done) begin
                  len_ff   <= ratio_in;
                  state_ff <= S_SQC;
               end
            end
            S_SQC: begin
               cnt2_ff  <= 32'(best_count_ff) * 32'(best_count_ff);
               state_ff <= S_DIV2;
            end
            S_DIV2:  state_ff <= S_WAIT2;
            S_WAIT2: begin
               if (div_rsp.done) begin
                  rsp_row_count <= ratio_in;
                  state_ff      <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_failure      <= fail_ff;
                  rsp_best_skew    <= fail_ff ? '0 : mid_adj[AngleW:1];
                  rsp_group_energy <= fail_ff ? '0 : best_energy_ff;
                  rsp_row_length   <= fail_ff ? '0 : len_ff;
                  if (fail_ff) rsp_row_count <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase

         // new sweep after a result or a register write
         if (emit_go || restart_ff) begin
            prev0_ff       <= '0;
            prev1_ff       <= '0;
            idx_ff         <= '0;
            gpos_ff        <= '0;
            score_ff       <= '0;
            gsum_ff        <= '0;
            energy_ff      <= '0;
            angle_ff       <= start_angle;
            first_ff       <= start_angle;
            last_ff        <= start_angle;
            best_score_ff  <= '0;
            best_energy_ff <= '0;
            best_count_ff  <= '0;
         end
      end
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IdxW'(MAX_BINS))
      else $error("bin index beyond limit");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !div_rsp.done)
      else $error("divider finished outside a wait");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_failure |-> rsp_group_energy == '0 && rsp_best_skew == '0)
      else $error("failure result carries data");

   a_emit: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> state_ff == S_IDLE && rsp_valid_ff && idx_ff == '0)
      else $error("result load did not restart sweep");

endmodule
`default_nettype wire

>>> hw/rtl/projection_skew_angle_search.sv
`default_nettype none
// Back end: a bin passes S_IDLE, S_MUL and S_ACC; one that closes a group of five or
// ends the histogram adds S_SQ and S_ENG (group-sum square, energy add), the last bin
// S_CMP (end-of-histogram compare). After the final angle two 56-step shift-subtract divisions run.
// Throughput is set by the back-end sequencer; a 2-entry queue decouples input.
// Synchronous active-high reset: center 0, delta 0, step 1, sweep at angle 0.
module projection_skew_angle_search #(
   parameter int MAX_BINS = psas_pkg::MaxBinsDefault
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [11:0] csr_wdata,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [15:0] req_bin_value,
   input  wire         req_last_bin,
   input  wire  [15:0] req_element_count,
   input  wire         req_build_failed,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [12:0] rsp_best_skew,
   output logic [47:0] rsp_group_energy,
   output logic [31:0] rsp_row_length,
   output logic [31:0] rsp_row_count,
   output logic        rsp_failure
);
   import psas_pkg::*;

   logic        q_valid;
   item_type    q_item;
   logic        q_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;

   psas_front u_front (
      .clock, .reset,
      .req_valid, .req_stall, .req_bin_value, .req_last_bin,
      .req_element_count, .req_build_failed,
      .q_valid, .q_item, .q_pop
   );

   psas_div u_div (
      .clock, .reset, .div_req, .div_rsp
   );

   psas_back #(.MAX_BINS(MAX_BINS)) u_back (
      .clock, .reset,
      .csr_we, .csr_index, .csr_wdata,
      .q_valid, .q_item, .q_pop,
      .div_req, .div_rsp,
      .rsp_valid, .rsp_stall, .rsp_best_skew, .rsp_group_energy,
      .rsp_row_length, .rsp_row_count, .rsp_failure
   );

endmodule
`default_nettype wire
